// File: design/rotc_pkg.sv
`default_nettype none
package rotc_pkg;

    // Capture counter and trim code widths
    localparam int COUNTER_BITS = 16;
    localparam int TRIM_BITS    = 5;

    // Configuration register widths
    localparam int NOM_W = 28;
    localparam int TGT_W = 20;
    localparam int TOL_W = 16;
    localparam int CFG_W = NOM_W;

    // Stream payload widths (packed fields, padded to whole bytes)
    localparam int IN_TDATA_W   = ((COUNTER_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + NOM_W + TRIM_BITS + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Divider step counter
    localparam int DIV_CNT_W = $clog2(NOM_W);

    // Reset values
    localparam logic [NOM_W-1:0]     NOM_RESET  = NOM_W'(16000000);
    localparam logic [TGT_W-1:0]     TGT_RESET  = TGT_W'(32768);
    localparam logic [TOL_W-1:0]     TOL_RESET  = TOL_W'(20);
    localparam logic [TRIM_BITS-1:0] TRIM_RESET = TRIM_BITS'(6);

    // Register indexes
    typedef enum logic [1:0] {
        REG_NOMINAL_CLOCK = 2'd0,
        REG_TARGET        = 2'd1,
        REG_TOLERANCE     = 2'd2,
        REG_TRIM_START    = 2'd3
    } cfg_index_t;

endpackage
`default_nettype wire

// File: design/rc_oscillator_trim_calibrator_top.sv
`default_nettype none
// RC oscillator trim calibrator.
// Slave stream (s_*): one transfer per timer capture taken at a reference rising
// edge. Captures pair up: the first is held, the second closes a period
// (modulo 2^COUNTER_BITS) and the block divides the nominal clock by it to get
// the measured reference frequency, then, unless already locked, steps the
// trim code toward target and tests for lock.
// Master stream (m_*): exactly one result transfer per accepted capture.
// A first capture or a zero period goes straight to the emit state and
// loads the output register once it is free. A full measurement runs the
// restoring divider, which retires one quotient bit per cycle, then compare,
// lock test and output load (an already locked block or an exact match skips
// the lock test). One capture is in flight at a time: the block takes no new
// capture until the current result has loaded the output register.
// Stall: a finished result holds in the output register until m_tready; the
// block accepts the next capture meanwhile and parks that result until the
// register frees up.
// Reset (aresetn low, synchronous): config registers return to their defaults,
// trim loads the default start code, lock and the held first edge clear.
// Config: write only while idle; a trim_start write restarts calibration.
module rc_oscillator_trim_calibrator_top
    import rotc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Configuration write port
    input  wire logic                   cfg_wr_en,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wdata,
    // Capture input: tdata = captured_count
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // Result output: tdata = measurement_done, measured_freq, trim_value,
    // calibration_locked, zero pad (lowest bit first)
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CMP,
        ST_LOCK,
        ST_EMIT
    } state_t;

    state_t                  state_reg;

    // Configuration registers
    logic [NOM_W-1:0]        nominal_reg;
    logic [TGT_W-1:0]        target_reg;
    logic [TOL_W-1:0]        tolerance_reg;

    // Calibration state
    logic [COUNTER_BITS-1:0] first_edge_reg;
    logic                    have_first_reg;
    logic [TRIM_BITS-1:0]    trim_reg;
    logic                    locked_reg;

    // Divider: dividend shifts out the top while quotient bits shift in below
    logic [NOM_W-1:0]        dq_reg;
    logic [COUNTER_BITS-1:0] divisor_reg;
    logic [COUNTER_BITS-1:0] rem_reg;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;
    logic                    done_reg;
    logic [NOM_W-1:0]        diff_reg;

    // Output register
    logic                    m_valid_reg;
    logic [OUT_TDATA_W-1:0]  m_data_reg;

    logic [COUNTER_BITS-1:0] cap;
    logic [COUNTER_BITS-1:0] period;
    logic [COUNTER_BITS:0]   rem_shift;
    logic [COUNTER_BITS:0]   rem_sub;
    logic                    qbit;
    logic [NOM_W-1:0]        target_ext;
    logic                    out_free;

    assign cap        = s_tdata[COUNTER_BITS-1:0];
    assign period     = cap - first_edge_reg;
    assign rem_shift  = {rem_reg, dq_reg[NOM_W-1]};
    assign rem_sub    = rem_shift - {1'b0, divisor_reg};
    assign qbit       = ~rem_sub[COUNTER_BITS];
    assign target_ext = {{(NOM_W-TGT_W){1'b0}}, target_reg};
    assign out_free   = ~m_valid_reg | m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            nominal_reg    <= NOM_RESET;
            target_reg     <= TGT_RESET;
            tolerance_reg  <= TOL_RESET;
            first_edge_reg <= '0;
            have_first_reg <= 1'b0;
            trim_reg       <= TRIM_RESET;
            locked_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            div_cnt_reg    <= '0;
        end else begin
            // Drop the result once the receiver takes it, unless a new one loads
            if (m_valid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_index))
                    REG_NOMINAL_CLOCK: nominal_reg   <= cfg_wdata[NOM_W-1:0];
                    REG_TARGET:        target_reg    <= cfg_wdata[TGT_W-1:0];
                    REG_TOLERANCE:     tolerance_reg <= cfg_wdata[TOL_W-1:0];
                    REG_TRIM_START: begin
                        // Restart calibration from the new start code
                        trim_reg       <= cfg_wdata[TRIM_BITS-1:0];
                        locked_reg     <= 1'b0;
                        have_first_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (!have_first_reg) begin
                            // Hold the opening edge of the pair
                            first_edge_reg <= cap;
                            have_first_reg <= 1'b1;
                            done_reg       <= 1'b0;
                            dq_reg         <= '0;
                            state_reg      <= ST_EMIT;
                        end else begin
                            have_first_reg <= 1'b0;
                            if (period == '0) begin
                                done_reg  <= 1'b0;
                                dq_reg    <= '0;
                                state_reg <= ST_EMIT;
                            end else begin
                                divisor_reg <= period;
                                dq_reg      <= nominal_reg;
                                rem_reg     <= '0;
                                div_cnt_reg <= '0;
                                state_reg   <= ST_DIV;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    // One quotient bit per cycle
                    rem_reg     <= qbit ? rem_sub[COUNTER_BITS-1:0]
                                        : rem_shift[COUNTER_BITS-1:0];
                    dq_reg      <= {dq_reg[NOM_W-2:0], qbit};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_CNT_W'(NOM_W - 1)) begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    done_reg <= 1'b1;
                    if (locked_reg) begin
                        state_reg <= ST_EMIT;
                    end else if (dq_reg == target_ext) begin
                        locked_reg <= 1'b1;
                        state_reg  <= ST_EMIT;
                    end else if (dq_reg > target_ext) begin
                        if (trim_reg != '1) begin
                            trim_reg <= trim_reg + 1'b1;
                        end
                        diff_reg  <= dq_reg - target_ext;
                        state_reg <= ST_LOCK;
                    end else begin
                        if (trim_reg != '0) begin
                            trim_reg <= trim_reg - 1'b1;
                        end
                        diff_reg  <= target_ext - dq_reg;
                        state_reg <= ST_LOCK;
                    end
                end
                ST_LOCK: begin
                    if (diff_reg < {{(NOM_W-TOL_W){1'b0}}, tolerance_reg}) begin
                        locked_reg <= 1'b1;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    // Park here until the output register frees up
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= OUT_TDATA_W'({locked_reg, trim_reg,
                                                     dq_reg, done_reg});
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
